// ===== hdl/spr_pkg.sv =====
// Shared types, codes and constants for the serial port register block.
// No dependencies; imported by spr_read_mux and serial_port_register_block_unit.
package spr_pkg;

    // Item operation codes
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // Register slot indexes
    typedef enum logic [2:0] {
        IDX_DATA_LO = 3'd0,
        IDX_DATA_HI = 3'd1,
        IDX_MULTI2  = 3'd2,
        IDX_MULTI3  = 3'd3,
        IDX_CTRL    = 3'd4,
        IDX_DATA8   = 3'd5,
        IDX_MODE    = 3'd6
    } t_reg_idx;

    localparam int unsigned NUM_REGS = 7;

    // Byte offsets of the serial registers
    localparam logic [9:0] OFF_DATA_LO = 10'h120;
    localparam logic [9:0] OFF_DATA_HI = 10'h122;
    localparam logic [9:0] OFF_MULTI2  = 10'h124;
    localparam logic [9:0] OFF_MULTI3  = 10'h126;
    localparam logic [9:0] OFF_CTRL    = 10'h128;
    localparam logic [9:0] OFF_DATA8   = 10'h12A;
    localparam logic [9:0] OFF_MODE    = 10'h134;

    // Control mode field, bits 13:12
    localparam logic [1:0] MODE_8BIT  = 2'd0;
    localparam logic [1:0] MODE_32BIT = 2'd1;
    localparam logic [1:0] MODE_UART  = 2'd3;

    // Control bits
    localparam int unsigned CTRL_INT_CLK = 0;
    localparam int unsigned CTRL_FAST    = 1;
    localparam int unsigned CTRL_SO_BIT  = 5;
    localparam int unsigned CTRL_START   = 7;
    localparam int unsigned CTRL_IRQ_EN  = 14;

    // Read patterns
    localparam logic [15:0] CTRL_READ_SET = 16'h4F8F;
    localparam logic [15:0] MODE_READ_GP  = 16'h81FF;
    localparam logic [15:0] MODE_READ_JB  = 16'hC1FC;
    localparam logic [15:0] MODE_READ_NRM = 16'h01F5;
    localparam logic [15:0] MODE_READ_OTH = 16'h01FF;

    // Countdown lengths: bits * per-bit length + start overhead
    localparam int unsigned CNT_W       = 12;
    localparam int unsigned BITS_8      = 8;
    localparam int unsigned BITS_32     = 32;
    localparam int unsigned PER_BIT_FST = 8;
    localparam int unsigned PER_BIT_SLW = 64;
    localparam int unsigned START_OVH   = 40;
    localparam logic [CNT_W-1:0] CNT_8_FAST  = CNT_W'(BITS_8 * PER_BIT_FST + START_OVH);
    localparam logic [CNT_W-1:0] CNT_8_SLOW  = CNT_W'(BITS_8 * PER_BIT_SLW + START_OVH);
    localparam logic [CNT_W-1:0] CNT_32_FAST = CNT_W'(BITS_32 * PER_BIT_FST + START_OVH);
    localparam logic [CNT_W-1:0] CNT_32_SLOW = CNT_W'(BITS_32 * PER_BIT_SLW + START_OVH);

    // Offset decode result
    typedef struct packed {
        logic     hit;
        t_reg_idx idx;
    } t_decode;

    function automatic t_decode decode_offset(input logic [9:0] off);
        t_decode d;
        d.hit = 1'b1;
        case (off)
            OFF_DATA_LO: d.idx = IDX_DATA_LO;
            OFF_DATA_HI: d.idx = IDX_DATA_HI;
            OFF_MULTI2:  d.idx = IDX_MULTI2;
            OFF_MULTI3:  d.idx = IDX_MULTI3;
            OFF_CTRL:    d.idx = IDX_CTRL;
            OFF_DATA8:   d.idx = IDX_DATA8;
            OFF_MODE:    d.idx = IDX_MODE;
            default: begin
                d.hit = 1'b0;
                d.idx = IDX_DATA_LO;
            end
        endcase
        return d;
    endfunction

endpackage

// ===== hdl/spr_read_mux.sv =====
// Read value formatting for the serial registers: mode masks and forced patterns.
// Depends on spr_pkg.
module spr_read_mux
    import spr_pkg::*;
(
    input  t_reg_idx    i_idx,
    input  logic [15:0] i_value,
    input  logic [15:0] i_ctrl,
    output logic [15:0] o_data
);

    logic [1:0]  mode;
    logic [15:0] mode_bits;
    logic [1:0]  top;

    assign mode      = i_ctrl[13:12];
    assign mode_bits = {2'b00, mode, 12'h000};
    assign top       = i_value[15:14];

    // Per-register read view
    always_comb begin
        case (i_idx)
            IDX_DATA_LO, IDX_DATA_HI: begin
                o_data = (mode == MODE_32BIT) ? i_value : 16'h0000;
            end
            IDX_MULTI2, IDX_MULTI3: begin
                o_data = 16'h0000;
            end
            IDX_CTRL: begin
                o_data = CTRL_READ_SET | mode_bits;
                if (mode == MODE_UART) begin
                    o_data[CTRL_SO_BIT] = i_value[CTRL_SO_BIT];
                end
            end
            IDX_DATA8: begin
                o_data = (mode == MODE_UART) ? 16'h0000 : i_value;
            end
            default: begin
                if (top == 2'b10) begin
                    o_data = MODE_READ_GP;
                end else if (top == 2'b11) begin
                    o_data = MODE_READ_JB;
                end else if (mode == MODE_8BIT || mode == MODE_32BIT) begin
                    o_data = MODE_READ_NRM;
                end else begin
                    o_data = MODE_READ_OTH;
                end
            end
        endcase
    end

endmodule

// ===== hdl/serial_port_register_block_unit.sv =====
// Serial port register block: seven halfword registers and a transfer countdown.
// Depends on spr_pkg and spr_read_mux.
//
// Usage
//   Input channel (i_valid / o_stall) carries one item per transfer: a halfword
//   read, a halfword write, or a time tick with an elapsed cycle count.
//   Output channel (o_valid / i_stall) returns exactly one result per item, in
//   order: read data, hit flag, serial interrupt pulse and busy flag.
//   Each item's result is registered: decode, state update and read formatting
//   settle while the item sits in the input register, and the result register
//   loads when the output stage advances. The result transfers at the earliest
//   on the edge after that.
//   Throughput is one item per cycle without receiver stalls, set by the single
//   register-to-register pass that updates the register file and countdown.
//   When the receiver stalls, the result register holds and the input register
//   may still take one more item; o_stall rises only when both are full.
//   Synchronous active-low reset clears all seven registers, the transfer
//   flag and the countdown, and empties both stages.
//   Odd or unknown offsets return hit low and zero data and store nothing.
//   A control write arms or cancels the countdown; ticks count it down and
//   pulse the interrupt on completion when enabled.
module serial_port_register_block_unit
    import spr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [9:0]  i_io_offset,
    input  logic [15:0] i_write_data,
    input  logic [15:0] i_tick_cycles,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_read_data,
    output logic        o_hit,
    output logic        o_serial_irq,
    output logic        o_transfer_busy
);

    // Input register
    logic        r_in_valid;
    t_op         r_op;
    logic [9:0]  r_off;
    logic [15:0] r_wdata;
    logic [15:0] r_cyc;

    // Block state
    logic [15:0]      r_regs [NUM_REGS];
    logic [15:0]      n_regs [NUM_REGS];
    logic             r_active, n_active;
    logic [CNT_W-1:0] r_cycles, n_cycles;

    // Result register
    logic        r_out_valid;
    logic [15:0] r_rdata, n_rdata;
    logic        r_hit, n_hit;
    logic        r_irq, n_irq;
    logic        r_busy;

    logic        advance;
    logic        in_take;
    t_decode     dec;
    logic [15:0] rd_fmt;
    logic [15:0] ctrl;
    logic [1:0]  wr_mode;

    assign advance = !r_out_valid || !i_stall;
    assign o_stall = r_in_valid && !advance;
    assign in_take = i_valid && !o_stall;

    assign dec  = decode_offset(r_off);
    assign ctrl = r_regs[IDX_CTRL];

    spr_read_mux u_read_mux (
        .i_idx   (dec.idx),
        .i_value (r_regs[dec.idx]),
        .i_ctrl  (ctrl),
        .o_data  (rd_fmt)
    );

    assign wr_mode = r_wdata[13:12];

    // Next state and result for the item in the input register
    always_comb begin
        n_regs   = r_regs;
        n_active = r_active;
        n_cycles = r_cycles;
        n_rdata  = 16'h0000;
        n_hit    = 1'b0;
        n_irq    = 1'b0;
        case (r_op)
            OP_READ: begin
                if (dec.hit) begin
                    n_hit   = 1'b1;
                    n_rdata = rd_fmt;
                end
            end
            OP_WRITE: begin
                if (dec.hit) begin
                    n_hit           = 1'b1;
                    n_regs[dec.idx] = r_wdata;
                    if (dec.idx == IDX_CTRL) begin
                        // control write re-arms or cancels the countdown
                        n_active = 1'b0;
                        n_cycles = '0;
                        if (r_wdata[CTRL_START] && r_wdata[CTRL_INT_CLK]) begin
                            if (wr_mode == MODE_8BIT) begin
                                n_active = 1'b1;
                                n_cycles = r_wdata[CTRL_FAST] ? CNT_8_FAST : CNT_8_SLOW;
                            end else if (wr_mode == MODE_32BIT) begin
                                n_active = 1'b1;
                                n_cycles = r_wdata[CTRL_FAST] ? CNT_32_FAST : CNT_32_SLOW;
                            end
                        end
                    end
                end
            end
            OP_TICK: begin
                if (r_active && r_cyc != 16'h0000) begin
                    if (r_cyc < {{(16-CNT_W){1'b0}}, r_cycles}) begin
                        n_cycles = r_cycles - r_cyc[CNT_W-1:0];
                    end else begin
                        n_active = 1'b0;
                        n_cycles = '0;
                        n_irq    = ctrl[CTRL_IRQ_EN];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_active    <= 1'b0;
            r_cycles    <= '0;
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= 16'h0000;
            end
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_regs   <= n_regs;
                    r_active <= n_active;
                    r_cycles <= n_cycles;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op    <= t_op'(i_opcode);
            r_off   <= i_io_offset;
            r_wdata <= i_write_data;
            r_cyc   <= i_tick_cycles;
        end
        if (advance && r_in_valid) begin
            r_rdata <= n_rdata;
            r_hit   <= n_hit;
            r_irq   <= n_irq;
            r_busy  <= n_active;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_read_data     = r_rdata;
    assign o_hit           = r_hit;
    assign o_serial_irq    = r_irq;
    assign o_transfer_busy = r_busy;

endmodule
